// File: design/un2d_pkg.sv
// ----------------------------------------------------------------------------
// un2d_pkg
// Shared widths, constants, reciprocals and item types for the unix
// nanoseconds to UTC date and time converter.
// ----------------------------------------------------------------------------
package un2d_pkg;

    localparam int NANOS_W  = 64;
    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int NANO_W   = 30;

    localparam int NS_PER_SEC    = 1000000000;
    localparam int SEC_PER_DAY   = 86400;
    localparam int SEC_PER_HOUR  = 3600;
    localparam int SEC_PER_MIN   = 60;
    localparam int DAY_SHIFT     = 719468;
    localparam int DAYS_PER_ERA  = 146097;
    localparam int DAYS_PER_YEAR = 365;
    localparam int YEARS_PER_ERA = 400;

    // bias of whole days that makes every input non-negative
    localparam int BIAS_DAYS = 106752;
    localparam int BIASED_W  = NANOS_W + 1;
    localparam logic [BIASED_W-1:0] NS_BIAS = 65'd9223372800000000000;

    // long division by constants
    localparam int DIV_STEP    = 4;
    localparam int SECS_W      = 36;
    localparam int NS_STAGES   = SECS_W / DIV_STEP;
    localparam int DAYS_Q_W    = 20;
    localparam int SOD_W       = 17;
    localparam int SD_STAGES   = DAYS_Q_W / DIV_STEP;
    localparam int DAYS_W      = 18;

    localparam int DATE_LAT = 8;
    localparam int TOD_LAT  = 4;

    // reciprocals, rounded up, exact over the operand ranges used
    localparam int RCP_1460_SH  = 32;
    localparam logic [21:0] RCP_1460 = 22'(((64'd1 << 32) + 64'd1459) / 64'd1460);
    localparam int RCP_36524_SH = 33;
    localparam logic [17:0] RCP_36524 = 18'(((64'd1 << 33) + 64'd36523) / 64'd36524);
    localparam int RCP_365_SH   = 32;
    localparam logic [23:0] RCP_365 = 24'(((64'd1 << 32) + 64'd364) / 64'd365);
    localparam int RCP_100_SH   = 16;
    localparam logic [9:0] RCP_100 = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
    localparam int RCP_153_SH   = 20;
    localparam logic [12:0] RCP_153 = 13'(((64'd1 << 20) + 64'd152) / 64'd153);
    localparam int RCP_3600_SH  = 32;
    localparam logic [20:0] RCP_3600 = 21'(((64'd1 << 32) + 64'd3599) / 64'd3600);
    localparam int RCP_60_SH    = 18;
    localparam logic [12:0] RCP_60 = 13'(((64'd1 << 18) + 64'd59) / 64'd60);

    typedef struct packed {
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } tod_t;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic [NANO_W-1:0]   nanosecond;
    } result_t;

endpackage

// File: design/unix_nanos_to_utc_datetime.sv
// ----------------------------------------------------------------------------
// unix_nanos_to_utc_datetime
// Converts signed nanoseconds since the unix epoch to UTC calendar date,
// time of day and nanosecond fraction.
//
//   channel  handshake             fields
//   -------  --------------------  ------------------------------------------
//   in       in_valid / in_ready   epoch_ns
//   out      out_valid / out_ready calendar_year, month, day_of_month, hour,
//                                  minute, second, nanosecond
//
// One item per cycle while in_ready is high; each result passes the bias
// stage, the 9-stage divide by one billion, the 5-stage divide by 86400
// and the 8-stage date conversion, then the output register.
// Reset clears only valid bits and the output skid flags.
// A stalled output fills the spare entry, then in_ready drops and the whole
// pipeline holds until the output drains.
// ----------------------------------------------------------------------------
module unix_nanos_to_utc_datetime (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [un2d_pkg::NANOS_W-1:0]  epoch_ns,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [un2d_pkg::YEAR_W-1:0]          calendar_year,
    output logic [un2d_pkg::MONTH_W-1:0]         month,
    output logic [un2d_pkg::DAY_W-1:0]           day_of_month,
    output logic [un2d_pkg::HOUR_W-1:0]          hour,
    output logic [un2d_pkg::MINUTE_W-1:0]        minute,
    output logic [un2d_pkg::SECOND_W-1:0]        second,
    output logic [un2d_pkg::NANO_W-1:0]          nanosecond
);

    localparam int FRAC_DLY = un2d_pkg::SD_STAGES + un2d_pkg::DATE_LAT;
    localparam int TOD_DLY  = un2d_pkg::DATE_LAT - un2d_pkg::TOD_LAT;

    logic                             en;
    logic                             full;
    logic                             ns_v;
    logic [un2d_pkg::SECS_W-1:0]      secs;
    logic [un2d_pkg::NANO_W-1:0]      frac;
    logic                             sd_v;
    logic [un2d_pkg::DAYS_W-1:0]      days;
    logic [un2d_pkg::SOD_W-1:0]       sod;
    logic                             date_v;
    logic [un2d_pkg::YEAR_W-1:0]      year;
    logic [un2d_pkg::MONTH_W-1:0]     mon;
    logic [un2d_pkg::DAY_W-1:0]       mday;
    un2d_pkg::tod_t                   tod;
    logic [un2d_pkg::NANO_W-1:0]      frac_dly_reg [FRAC_DLY];
    un2d_pkg::tod_t                   tod_dly_reg  [TOD_DLY];
    un2d_pkg::result_t                res;
    un2d_pkg::result_t                out_res;

    assign en       = !full;
    assign in_ready = !full;

    un2d_nsdiv u_nsdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_v     (in_valid),
        .epoch_ns (epoch_ns),
        .out_v    (ns_v),
        .secs     (secs),
        .frac     (frac)
    );

    un2d_secdiv u_secdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .in_v  (ns_v),
        .secs  (secs),
        .out_v (sd_v),
        .days  (days),
        .sod   (sod)
    );

    un2d_date u_date (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .in_v  (sd_v),
        .days  (days),
        .out_v (date_v),
        .year  (year),
        .month (mon),
        .day   (mday)
    );

    un2d_tod u_tod (
        .clk (clk),
        .en  (en),
        .sod (sod),
        .tod (tod)
    );

    // align fraction and time of day with the date path
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            frac_dly_reg[0] <= frac;
            for (int i = 1; i < FRAC_DLY; i++)
            begin
                frac_dly_reg[i] <= frac_dly_reg[i-1];
            end
            tod_dly_reg[0] <= tod;
            for (int i = 1; i < TOD_DLY; i++)
            begin
                tod_dly_reg[i] <= tod_dly_reg[i-1];
            end
        end
    end

    always_comb
    begin
        res.year       = year;
        res.month      = mon;
        res.day        = mday;
        res.hour       = tod_dly_reg[TOD_DLY-1].hour;
        res.minute     = tod_dly_reg[TOD_DLY-1].minute;
        res.second     = tod_dly_reg[TOD_DLY-1].second;
        res.nanosecond = frac_dly_reg[FRAC_DLY-1];
    end

    un2d_oq u_oq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_v    (date_v),
        .push_data (res),
        .full      (full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_res)
    );

    assign calendar_year = out_res.year;
    assign month         = out_res.month;
    assign day_of_month  = out_res.day;
    assign hour          = out_res.hour;
    assign minute        = out_res.minute;
    assign second        = out_res.second;
    assign nanosecond    = out_res.nanosecond;

endmodule

// File: design/un2d_nsdiv.sv
// ----------------------------------------------------------------------------
// un2d_nsdiv
// Biases the signed nanosecond count and divides it by one billion in a
// pipelined long division, four quotient bits per stage.
// ----------------------------------------------------------------------------
module un2d_nsdiv (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_v,
    input  logic signed [un2d_pkg::NANOS_W-1:0] epoch_ns,
    output logic                                out_v,
    output logic [un2d_pkg::SECS_W-1:0]         secs,
    output logic [un2d_pkg::NANO_W-1:0]         frac
);

    localparam int Q_W    = un2d_pkg::SECS_W;
    localparam int R_W    = un2d_pkg::NANO_W;
    localparam int S      = un2d_pkg::NS_STAGES;
    localparam int B_W    = un2d_pkg::BIASED_W;
    localparam int INIT_W = B_W - Q_W;
    localparam logic [R_W:0] DIVISOR = (R_W + 1)'(un2d_pkg::NS_PER_SEC);

    logic [B_W-1:0] biased_reg;
    logic           bias_v_reg;
    logic [R_W-1:0] rem_reg  [S];
    logic [Q_W-1:0] quo_reg  [S];
    logic [R_W-1:0] rem_next [S];
    logic [Q_W-1:0] quo_next [S];
    logic [S-1:0]   v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_v_reg <= 1'b0;
            v_reg      <= '0;
        end
        else if (en)
        begin
            bias_v_reg <= in_v;
            v_reg      <= {v_reg[S-2:0], bias_v_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            biased_reg <= {epoch_ns[un2d_pkg::NANOS_W-1], epoch_ns} + un2d_pkg::NS_BIAS;
            for (int s = 0; s < S; s++)
            begin
                rem_reg[s] <= rem_next[s];
                quo_reg[s] <= quo_next[s];
            end
        end
    end

    for (genvar s = 0; s < S; s++)
    begin : g_stage
        logic [R_W-1:0] r_in;
        logic [Q_W-1:0] q_in;
        logic [R_W-1:0] r_out;
        logic [Q_W-1:0] q_out;

        if (s == 0)
        begin : g_first
            assign r_in = R_W'(biased_reg[B_W-1 -: INIT_W]);
            assign q_in = biased_reg[Q_W-1:0];
        end
        else
        begin : g_rest
            assign r_in = rem_reg[s-1];
            assign q_in = quo_reg[s-1];
        end

        always_comb
        begin
            logic [R_W:0]   trial;
            logic [R_W-1:0] r;
            logic [Q_W-1:0] q;
            r = r_in;
            q = q_in;
            for (int k = 0; k < un2d_pkg::DIV_STEP; k++)
            begin
                trial = {r, q[Q_W-1]};
                q     = {q[Q_W-2:0], 1'b0};
                if (trial >= DIVISOR)
                begin
                    trial = trial - DIVISOR;
                    q[0]  = 1'b1;
                end
                r = trial[R_W-1:0];
            end
            r_out = r;
            q_out = q;
        end

        assign rem_next[s] = r_out;
        assign quo_next[s] = q_out;
    end

    assign out_v = v_reg[S-1];
    assign secs  = quo_reg[S-1];
    assign frac  = rem_reg[S-1];

endmodule

// File: design/un2d_secdiv.sv
// ----------------------------------------------------------------------------
// un2d_secdiv
// Divides the biased second count by 86400 in a pipelined long division,
// giving the biased day number and the second of day.
// ----------------------------------------------------------------------------
module un2d_secdiv (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_v,
    input  logic [un2d_pkg::SECS_W-1:0]   secs,
    output logic                          out_v,
    output logic [un2d_pkg::DAYS_W-1:0]   days,
    output logic [un2d_pkg::SOD_W-1:0]    sod
);

    localparam int Q_W    = un2d_pkg::DAYS_Q_W;
    localparam int R_W    = un2d_pkg::SOD_W;
    localparam int S      = un2d_pkg::SD_STAGES;
    localparam int INIT_W = un2d_pkg::SECS_W - Q_W;
    localparam logic [R_W:0] DIVISOR = (R_W + 1)'(un2d_pkg::SEC_PER_DAY);

    logic [R_W-1:0] rem_reg  [S];
    logic [Q_W-1:0] quo_reg  [S];
    logic [R_W-1:0] rem_next [S];
    logic [Q_W-1:0] quo_next [S];
    logic [S-1:0]   v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[S-2:0], in_v};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < S; s++)
            begin
                rem_reg[s] <= rem_next[s];
                quo_reg[s] <= quo_next[s];
            end
        end
    end

    for (genvar s = 0; s < S; s++)
    begin : g_stage
        logic [R_W-1:0] r_in;
        logic [Q_W-1:0] q_in;
        logic [R_W-1:0] r_out;
        logic [Q_W-1:0] q_out;

        if (s == 0)
        begin : g_first
            assign r_in = R_W'(secs[un2d_pkg::SECS_W-1 -: INIT_W]);
            assign q_in = secs[Q_W-1:0];
        end
        else
        begin : g_rest
            assign r_in = rem_reg[s-1];
            assign q_in = quo_reg[s-1];
        end

        always_comb
        begin
            logic [R_W:0]   trial;
            logic [R_W-1:0] r;
            logic [Q_W-1:0] q;
            r = r_in;
            q = q_in;
            for (int k = 0; k < un2d_pkg::DIV_STEP; k++)
            begin
                trial = {r, q[Q_W-1]};
                q     = {q[Q_W-2:0], 1'b0};
                if (trial >= DIVISOR)
                begin
                    trial = trial - DIVISOR;
                    q[0]  = 1'b1;
                end
                r = trial[R_W-1:0];
            end
            r_out = r;
            q_out = q;
        end

        assign rem_next[s] = r_out;
        assign quo_next[s] = q_out;
    end

    assign out_v = v_reg[S-1];
    assign days  = quo_reg[S-1][un2d_pkg::DAYS_W-1:0];
    assign sod   = rem_reg[S-1];

endmodule

// File: design/un2d_date.sv
// ----------------------------------------------------------------------------
// un2d_date
// Pipelined days-to-civil conversion: era, day of era, year of era, day of
// year, March-based month, then calendar year, month and day.
// ----------------------------------------------------------------------------
module un2d_date (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_v,
    input  logic [un2d_pkg::DAYS_W-1:0]   days,
    output logic                          out_v,
    output logic [un2d_pkg::YEAR_W-1:0]   year,
    output logic [un2d_pkg::MONTH_W-1:0]  month,
    output logic [un2d_pkg::DAY_W-1:0]    day
);

    localparam int Z_W     = 20;
    localparam int DOE_W   = 18;
    localparam int ERA_W   = 3;
    localparam int ERA_MAX = 5;
    localparam int YOE_W   = 9;
    localparam int DOY_W   = 9;
    localparam int MP_W    = 4;
    localparam logic [Z_W-1:0] Z_OFF =
        Z_W'(un2d_pkg::DAY_SHIFT - un2d_pkg::BIAS_DAYS);

    function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
        logic [DOY_W-1:0] off;
        case (mp)
            4'd0:    off = 9'd0;
            4'd1:    off = 9'd31;
            4'd2:    off = 9'd61;
            4'd3:    off = 9'd92;
            4'd4:    off = 9'd122;
            4'd5:    off = 9'd153;
            4'd6:    off = 9'd184;
            4'd7:    off = 9'd214;
            4'd8:    off = 9'd245;
            4'd9:    off = 9'd275;
            4'd10:   off = 9'd306;
            4'd11:   off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

    logic [un2d_pkg::DATE_LAT-1:0] v_reg;

    logic [Z_W-1:0]   z_reg;
    logic [DOE_W-1:0] doe2_reg, doe3_reg, doe4_reg, doe5_reg;
    logic [ERA_W-1:0] era2_reg, era3_reg, era4_reg, era5_reg, era6_reg, era7_reg;
    logic [6:0]       q1460_reg;
    logic [2:0]       q36524_reg;
    logic             corner_reg;
    logic [DOE_W-1:0] n4_reg;
    logic [YOE_W-1:0] yoe5_reg, yoe6_reg, yoe7_reg;
    logic [DOY_W-1:0] doy6_reg, doy7_reg;
    logic [MP_W-1:0]  mp7_reg;
    logic [un2d_pkg::YEAR_W-1:0]  year_reg;
    logic [un2d_pkg::MONTH_W-1:0] month_reg;
    logic [un2d_pkg::DAY_W-1:0]   day_reg;

    logic [Z_W-1:0]   z_next;
    logic [ERA_W-1:0] era2_next;
    logic [DOE_W-1:0] doe2_next;
    logic [39:0]      p1460;
    logic [35:0]      p36524;
    logic [6:0]       q1460_next;
    logic [2:0]       q36524_next;
    logic             corner_next;
    logic [DOE_W-1:0] n4_next;
    logic [41:0]      p365;
    logic [YOE_W-1:0] yoe5_next;
    logic [18:0]      p100;
    logic [DOE_W-1:0] yday_base;
    logic [DOY_W-1:0] doy6_next;
    logic [10:0]      t153;
    logic [23:0]      p153;
    logic [MP_W-1:0]  mp7_next;
    logic [MP_W-1:0]  month_next;
    logic [un2d_pkg::DAY_W-1:0]  day_next;
    logic [un2d_pkg::YEAR_W-1:0] year_next;

    // era and day of era
    assign z_next = Z_W'(days) + Z_OFF;

    always_comb
    begin
        logic [Z_W-1:0] base;
        era2_next = '0;
        base      = '0;
        for (int k = 1; k <= ERA_MAX; k++)
        begin
            if (z_reg >= Z_W'(k * un2d_pkg::DAYS_PER_ERA))
            begin
                era2_next = ERA_W'(k);
                base      = Z_W'(k * un2d_pkg::DAYS_PER_ERA);
            end
        end
        doe2_next = DOE_W'(z_reg - base);
    end

    // leap corrections of the year of era
    assign p1460       = 40'(doe2_reg) * 40'(un2d_pkg::RCP_1460);
    assign p36524      = 36'(doe2_reg) * 36'(un2d_pkg::RCP_36524);
    assign q1460_next  = p1460[un2d_pkg::RCP_1460_SH +: 7];
    assign q36524_next = p36524[un2d_pkg::RCP_36524_SH +: 3];
    assign corner_next = (doe2_reg == DOE_W'(un2d_pkg::DAYS_PER_ERA - 1));

    assign n4_next = doe3_reg - DOE_W'(q1460_reg) + DOE_W'(q36524_reg)
                   - DOE_W'(corner_reg);

    assign p365      = 42'(n4_reg) * 42'(un2d_pkg::RCP_365);
    assign yoe5_next = p365[un2d_pkg::RCP_365_SH +: YOE_W];

    // day of year
    assign p100      = 19'(yoe5_reg) * 19'(un2d_pkg::RCP_100);
    assign yday_base = DOE_W'(yoe5_reg) * DOE_W'(un2d_pkg::DAYS_PER_YEAR)
                     + DOE_W'(yoe5_reg >> 2) - DOE_W'(p100[un2d_pkg::RCP_100_SH +: 2]);
    assign doy6_next = DOY_W'(doe5_reg - yday_base);

    // march-based month
    assign t153     = 11'(doy6_reg) * 11'd5 + 11'd2;
    assign p153     = 24'(t153) * 24'(un2d_pkg::RCP_153);
    assign mp7_next = p153[un2d_pkg::RCP_153_SH +: MP_W];

    // calendar fields
    assign month_next = (mp7_reg < 4'd10) ? mp7_reg + 4'd3 : mp7_reg - 4'd9;
    assign day_next   = un2d_pkg::DAY_W'(doy7_reg - month_start(mp7_reg) + 9'd1);
    assign year_next  = un2d_pkg::YEAR_W'(era7_reg) * un2d_pkg::YEAR_W'(un2d_pkg::YEARS_PER_ERA)
                      + un2d_pkg::YEAR_W'(yoe7_reg)
                      + un2d_pkg::YEAR_W'(month_next <= 4'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[un2d_pkg::DATE_LAT-2:0], in_v};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg      <= z_next;
            doe2_reg   <= doe2_next;
            era2_reg   <= era2_next;
            doe3_reg   <= doe2_reg;
            era3_reg   <= era2_reg;
            q1460_reg  <= q1460_next;
            q36524_reg <= q36524_next;
            corner_reg <= corner_next;
            n4_reg     <= n4_next;
            doe4_reg   <= doe3_reg;
            era4_reg   <= era3_reg;
            yoe5_reg   <= yoe5_next;
            doe5_reg   <= doe4_reg;
            era5_reg   <= era4_reg;
            doy6_reg   <= doy6_next;
            yoe6_reg   <= yoe5_reg;
            era6_reg   <= era5_reg;
            mp7_reg    <= mp7_next;
            doy7_reg   <= doy6_reg;
            yoe7_reg   <= yoe6_reg;
            era7_reg   <= era6_reg;
            year_reg   <= year_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
        end
    end

    assign out_v = v_reg[un2d_pkg::DATE_LAT-1];
    assign year  = year_reg;
    assign month = month_reg;
    assign day   = day_reg;

endmodule

// File: design/un2d_tod.sv
// ----------------------------------------------------------------------------
// un2d_tod
// Splits the second of day into hour, minute and second over four stages.
// ----------------------------------------------------------------------------
module un2d_tod (
    input  logic                         clk,
    input  logic                         en,
    input  logic [un2d_pkg::SOD_W-1:0]   sod,
    output un2d_pkg::tod_t               tod
);

    localparam int SOD_W = un2d_pkg::SOD_W;
    localparam int R_W   = 12;

    logic [SOD_W-1:0]              sod1_reg;
    logic [un2d_pkg::HOUR_W-1:0]   hour1_reg, hour2_reg, hour3_reg;
    logic [R_W-1:0]                r2_reg, r3_reg;
    logic [un2d_pkg::MINUTE_W-1:0] min3_reg;
    un2d_pkg::tod_t                tod_reg;

    logic [37:0]                   p3600;
    logic [un2d_pkg::HOUR_W-1:0]   hour1_next;
    logic [R_W-1:0]                r2_next;
    logic [24:0]                   p60;
    logic [un2d_pkg::MINUTE_W-1:0] min3_next;
    un2d_pkg::tod_t                tod_next;

    assign p3600      = 38'(sod) * 38'(un2d_pkg::RCP_3600);
    assign hour1_next = p3600[un2d_pkg::RCP_3600_SH +: un2d_pkg::HOUR_W];

    assign r2_next = R_W'(sod1_reg - SOD_W'(hour1_reg) * SOD_W'(un2d_pkg::SEC_PER_HOUR));

    assign p60       = 25'(r2_reg) * 25'(un2d_pkg::RCP_60);
    assign min3_next = p60[un2d_pkg::RCP_60_SH +: un2d_pkg::MINUTE_W];

    always_comb
    begin
        tod_next.hour   = hour3_reg;
        tod_next.minute = min3_reg;
        tod_next.second = un2d_pkg::SECOND_W'(r3_reg
                        - R_W'(min3_reg) * R_W'(un2d_pkg::SEC_PER_MIN));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sod1_reg  <= sod;
            hour1_reg <= hour1_next;
            hour2_reg <= hour1_reg;
            r2_reg    <= r2_next;
            hour3_reg <= hour2_reg;
            min3_reg  <= min3_next;
            r3_reg    <= r2_reg;
            tod_reg   <= tod_next;
        end
    end

    assign tod = tod_reg;

endmodule

// File: design/un2d_oq.sv
// ----------------------------------------------------------------------------
// un2d_oq
// Two-entry output skid: output register plus one spare, with a registered
// full flag that freezes the pipeline.
// ----------------------------------------------------------------------------
module un2d_oq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_v,
    input  un2d_pkg::result_t  push_data,
    output logic               full,
    output logic               out_valid,
    input  logic               out_ready,
    output un2d_pkg::result_t  out_data
);

    logic              full_reg, full_next;
    logic              out_v_reg, out_v_next;
    un2d_pkg::result_t main_reg, main_next;
    un2d_pkg::result_t spare_reg, spare_next;
    logic              push;

    assign push = push_v && !full_reg;

    always_comb
    begin
        full_next  = full_reg;
        out_v_next = out_v_reg;
        main_next  = main_reg;
        spare_next = spare_reg;
        if (!out_v_reg)
        begin
            out_v_next = push;
            main_next  = push_data;
        end
        else if (out_ready)
        begin
            if (full_reg)
            begin
                main_next = spare_reg;
                full_next = 1'b0;
            end
            else
            begin
                out_v_next = push;
                main_next  = push_data;
            end
        end
        else if (push)
        begin
            spare_next = push_data;
            full_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            full_reg  <= full_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg  <= main_next;
        spare_reg <= spare_next;
    end

    assign full      = full_reg;
    assign out_valid = out_v_reg;
    assign out_data  = main_reg;

endmodule

// File: sim/unix_nanos_to_utc_datetime_tb.sv
// ----------------------------------------------------------------------------
// unix_nanos_to_utc_datetime_tb
// Drives signed nanosecond timestamps into the converter and checks every
// calendar field of each result against a date and time calculation kept in
// the bench. Directed extremes and calendar edges come first, then random
// timestamps over the full range and near day boundaries. Both handshakes
// idle at random in two phases and never in the third; a pause lets the pipeline drain.
// ----------------------------------------------------------------------------
module unix_nanos_to_utc_datetime_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint NS_SEC       = 1000000000;
    localparam longint SECS_DAY     = 86400;
    localparam longint SECS_HOUR    = 3600;
    localparam longint SECS_MIN     = 60;
    localparam longint EPOCH_SHIFT  = 719468;
    localparam longint ERA_DAYS     = 146097;
    localparam longint NS_DAY       = NS_SEC * SECS_DAY;
    localparam longint DAY_SPAN     = 106750;
    localparam int     STALL_LIMIT  = 5000;
    localparam int     DRAIN_CYCLES = 40;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 in_valid = 1'b0;
    logic                                 in_ready;
    logic signed [un2d_pkg::NANOS_W-1:0]  epoch_ns = '0;
    logic                                 out_valid;
    logic                                 out_ready = 1'b0;
    logic [un2d_pkg::YEAR_W-1:0]          calendar_year;
    logic [un2d_pkg::MONTH_W-1:0]         month;
    logic [un2d_pkg::DAY_W-1:0]           day_of_month;
    logic [un2d_pkg::HOUR_W-1:0]          hour;
    logic [un2d_pkg::MINUTE_W-1:0]        minute;
    logic [un2d_pkg::SECOND_W-1:0]        second;
    logic [un2d_pkg::NANO_W-1:0]          nanosecond;

    un2d_pkg::result_t expected_dates[$];
    int      errors = 0;
    int      items_sent = 0;
    int      items_done = 0;
    int      stall_cycles = 0;
    int      send_idle_pct = 23;
    int      recv_idle_pct = 54;

    unix_nanos_to_utc_datetime dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .epoch_ns      (epoch_ns),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .calendar_year (calendar_year),
        .month         (month),
        .day_of_month  (day_of_month),
        .hour          (hour),
        .minute        (minute),
        .second        (second),
        .nanosecond    (nanosecond)
    );

    always #5 clk = ~clk;

    function automatic un2d_pkg::result_t nanos_to_datetime(
        input logic signed [un2d_pkg::NANOS_W-1:0] ns
    );
        longint  secs;
        longint  frac;
        longint  days;
        longint  sod;
        longint  z;
        longint  era;
        longint  doe;
        longint  yoe;
        longint  yr;
        longint  doy;
        longint  mp;
        longint  dd;
        longint  mm;
        un2d_pkg::result_t r;
        secs = longint'(ns) / NS_SEC;
        frac = longint'(ns) % NS_SEC;
        // floor division: borrow before the epoch
        if (frac < 0)
        begin
            frac += NS_SEC;
            secs -= 1;
        end
        days = secs / SECS_DAY;
        sod  = secs % SECS_DAY;
        if (sod < 0)
        begin
            sod  += SECS_DAY;
            days -= 1;
        end
        // civil date from day count, march-based year in 400-year eras
        z   = days + EPOCH_SHIFT;
        era = z / ERA_DAYS;
        doe = z - era * ERA_DAYS;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        yr  = yoe + era * 400;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        dd  = doy - (153 * mp + 2) / 5 + 1;
        mm  = (mp < 10) ? mp + 3 : mp - 9;
        if (mm <= 2)
            yr += 1;
        r.year       = un2d_pkg::YEAR_W'(yr);
        r.month      = un2d_pkg::MONTH_W'(mm);
        r.day        = un2d_pkg::DAY_W'(dd);
        r.hour       = un2d_pkg::HOUR_W'(sod / SECS_HOUR);
        r.minute     = un2d_pkg::MINUTE_W'((sod % SECS_HOUR) / SECS_MIN);
        r.second     = un2d_pkg::SECOND_W'(sod % SECS_MIN);
        r.nanosecond = un2d_pkg::NANO_W'(frac);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    task automatic compare_result(input un2d_pkg::result_t got, input un2d_pkg::result_t want);
        if (got.year !== want.year)
            report_mismatch("calendar_year", got.year, want.year);
        if (got.month !== want.month)
            report_mismatch("month", got.month, want.month);
        if (got.day !== want.day)
            report_mismatch("day_of_month", got.day, want.day);
        if (got.hour !== want.hour)
            report_mismatch("hour", got.hour, want.hour);
        if (got.minute !== want.minute)
            report_mismatch("minute", got.minute, want.minute);
        if (got.second !== want.second)
            report_mismatch("second", got.second, want.second);
        if (got.nanosecond !== want.nanosecond)
            report_mismatch("nanosecond", got.nanosecond, want.nanosecond);
    endtask

    // one process both predicts accepted items and checks accepted results
    always @(posedge clk)
    begin
        un2d_pkg::result_t got;
        un2d_pkg::result_t want;
        bit      moved;
        moved = 1'b0;
        if (in_valid && in_ready === 1'b1)
        begin
            expected_dates.push_back(nanos_to_datetime(epoch_ns));
            moved = 1'b1;
        end
        if (out_valid === 1'b1 && out_ready)
        begin
            moved = 1'b1;
            got.year       = calendar_year;
            got.month      = month;
            got.day        = day_of_month;
            got.hour       = hour;
            got.minute     = minute;
            got.second     = second;
            got.nanosecond = nanosecond;
            if (expected_dates.size() == 0)
            begin
                $display("%0t result item with no item pending", $realtime);
                errors++;
            end
            else
            begin
                want = expected_dates.pop_front();
                compare_result(got, want);
            end
            items_done++;
        end
        stall_cycles = moved ? 0 : stall_cycles + 1;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("unix_nanos_to_utc_datetime_tb: errors");
        $finish;
    end

    task automatic send_nanos(input logic signed [un2d_pkg::NANOS_W-1:0] ns);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        epoch_ns <= ns;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (items_done != items_sent)
            @(posedge clk);
    endtask

    function automatic longint day_start(input longint days);
        return days * NS_DAY;
    endfunction

    task automatic test_extremes();
        send_nanos(64'sh8000_0000_0000_0000);
        send_nanos(64'sh7fff_ffff_ffff_ffff);
        send_nanos(0);
        send_nanos(1);
        send_nanos(-1);
        send_nanos(NS_SEC - 1);
        send_nanos(NS_SEC);
        send_nanos(-NS_SEC);
        send_nanos(-NS_SEC - 1);
        send_nanos(-NS_SEC + 1);
        send_nanos(NS_DAY - 1);
        send_nanos(NS_DAY);
        send_nanos(-NS_DAY);
        send_nanos(-NS_DAY - 1);
        // leap day and century years
        send_nanos(day_start(11016));
        send_nanos(day_start(11017) - 1);
        send_nanos(day_start(-25508));
        send_nanos(day_start(-25508) - 1);
        send_nanos(day_start(47541) - 1);
        send_nanos(day_start(47541));
        send_nanos(64'sh5555_5555_5555_5555);
        send_nanos(64'shaaaa_aaaa_aaaa_aaaa);
        send_nanos(64'sh0000_0000_ffff_ffff);
    endtask

    task automatic test_random_full(input int count);
        repeat (count)
            send_nanos({$urandom, $urandom});
    endtask

    task automatic test_day_boundaries(input int count);
        longint days;
        longint offset;
        repeat (count)
        begin
            days = longint'($urandom_range(2 * DAY_SPAN)) - DAY_SPAN;
            case ($urandom_range(3))
                0: offset = longint'($urandom_range(2)) - 1;
                1: offset = longint'($urandom_range(NS_SEC)) - longint'($urandom_range(NS_SEC));
                2: offset = (longint'($urandom) * 20117 + $urandom_range(19999)) % NS_DAY;
                default: offset = longint'($urandom_range(1439)) * SECS_MIN * NS_SEC
                                  + longint'($urandom_range(2)) - 1;
            endcase
            send_nanos(day_start(days) + offset);
        end
    endtask

    task automatic test_drain_pause(input int count);
        test_random_full(count);
        wait_drain();
        test_day_boundaries(count);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 23;
        recv_idle_pct = 54;
        test_extremes();
        test_random_full(200);
        test_day_boundaries(200);
        test_drain_pause(20);

        send_idle_pct = 54;
        recv_idle_pct = 23;
        test_random_full(200);
        test_day_boundaries(200);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_full(200);
        test_day_boundaries(200);

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_dates.size() != 0)
        begin
            $display("%0t %0d items never produced a result", $realtime,
                     expected_dates.size());
            errors++;
        end
        if (errors == 0)
            $display("unix_nanos_to_utc_datetime_tb: clean");
        else
            $display("unix_nanos_to_utc_datetime_tb: errors");
        $finish;
    end

endmodule
